/* hw/rtl/beacon_ap_table_update_unit_defines.svh */
// Assertion macros used by the access point table update unit.
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while reset is high.
`ifndef BEACON_AP_TABLE_UPDATE_UNIT_DEFINES_SVH
`define BEACON_AP_TABLE_UPDATE_UNIT_DEFINES_SVH

// The property must hold at every sampled edge.
`define BAPT_ASSERT_NOW(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next sampled edge.
`define BAPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bapt_pkg.sv */
`timescale 1ns / 1ps

package bapt_pkg;

  localparam int ENTRY_COUNT_DEF   = 4;
  localparam int FULL_LIFETIME_DEF = 1024;
  localparam int SSID_MAX          = 32;
  localparam int SSID_WORDS        = 4;
  localparam int SLOT_W            = 2;
  localparam int MASK_W            = 4;

  localparam logic MODE_BEACON = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_MATCHED  = 3'd0,
    ST_FILLED   = 3'd1,
    ST_REPLACED = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_REJECTED = 3'd4,
    ST_TICK     = 3'd5
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  channel;
    logic [47:0] bssid;
    logic [7:0]  signal_strength;
    logic [7:0]  ssid_length;
    logic [63:0] ssid_word0;
    logic [63:0] ssid_word1;
    logic [63:0] ssid_word2;
    logic [63:0] ssid_word3;
    logic [15:0] beacon_period;
    logic [15:0] capability;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [MASK_W-1:0]    expired_mask;
  } rsp_t;

  // Byte mask for one 64-bit SSID word: a byte is kept when its position
  // in the SSID lies below the length.
  function automatic logic [63:0] ssid_keep(input logic [5:0] len, input logic [1:0] word);
    logic [63:0] keep;
    logic [5:0]  pos;
    keep = '0;
    for (int b = 0; b < 8; b++) begin
      pos = {1'b0, word, 3'(b)};
      keep[b*8 +: 8] = {8{pos < len}};
    end
    return keep;
  endfunction

endpackage

/* hw/rtl/beacon_ap_table_update_unit.sv */
`timescale 1ns / 1ps
// Each item's result is computed combinationally and registered into the result queue when the item is accepted.
// Throughput: one item per cycle; a two-entry result queue lets input keep flowing while the
// consumer stalls for one item, and ready drops only when both queue entries are full.
// Reset (synchronous, active high) clears every lifetime and signal strength, which empties
// the whole table at once, and empties the result queue.
module beacon_ap_table_update_unit import bapt_pkg::*; #(
  parameter int ENTRY_COUNT   = ENTRY_COUNT_DEF,
  parameter int FULL_LIFETIME = FULL_LIFETIME_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

`include "beacon_ap_table_update_unit_defines.svh"

  localparam int LIFE_W = $clog2(FULL_LIFETIME + 1);
  localparam int IDX_W  = $clog2(ENTRY_COUNT);

  // Access point table. Lifetime and strength decide every result, so they
  // carry reset; the rest of the entry is plain payload.
  logic [ENTRY_COUNT-1:0][LIFE_W-1:0]           lifetime;
  logic [ENTRY_COUNT-1:0][7:0]                  strength;
  logic [ENTRY_COUNT-1:0][3:0]                  channel;
  logic [ENTRY_COUNT-1:0][47:0]                 bssid;
  logic [ENTRY_COUNT-1:0][5:0]                  ssid_len;
  logic [ENTRY_COUNT-1:0][SSID_WORDS-1:0][63:0] ssid;
  logic [ENTRY_COUNT-1:0][15:0]                 period;
  logic [ENTRY_COUNT-1:0][15:0]                 capability;

  // Result queue: head is presented on the output, tail is the skid entry.
  logic [1:0] count;
  logic [1:0] count_next;
  rsp_t       head;
  rsp_t       tail;

  logic                               req_fire;
  logic                               rsp_fire;
  logic                               is_tick;
  logic                               rejected;
  logic                               res_write;
  logic                               wr_en;
  logic [ENTRY_COUNT-1:0]             occupied;
  logic [ENTRY_COUNT-1:0]             match;
  logic [ENTRY_COUNT-1:0]             expired;
  logic [ENTRY_COUNT-1:0][LIFE_W-1:0] aged;
  logic [MASK_W-1:0]                  mask_low;
  logic [SSID_WORDS-1:0][63:0]        ssid_in;
  status_t                            sel_status;
  logic [IDX_W-1:0]                   sel_slot;
  rsp_t                               res;

  assign req_ready = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = head;
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;

  assign is_tick  = (req.mode == MODE_TICK);
  assign rejected = (req.ssid_length > 8'(SSID_MAX));
  assign ssid_in  = {req.ssid_word3, req.ssid_word2, req.ssid_word1, req.ssid_word0};

  // Per-entry lookup and aging terms; these are independent across entries.
  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      occupied[i] = (strength[i] != 8'd0);
      match[i]    = occupied[i] && (bssid[i] == req.bssid);
      expired[i]  = (lifetime[i] == LIFE_W'(1));
      aged[i]     = (lifetime[i] != '0) ? lifetime[i] - LIFE_W'(1) : '0;
    end
  end

  // Only the first four entries are reported in the expiry mask.
  for (genvar j = 0; j < MASK_W; j++) begin : g_mask
    if (j < ENTRY_COUNT) begin : g_real
      assign mask_low[j] = expired[j];
    end else begin : g_pad
      assign mask_low[j] = 1'b0;
    end
  end

  bapt_select #(
    .ENTRY_COUNT   (ENTRY_COUNT),
    .FULL_LIFETIME (FULL_LIFETIME),
    .LIFE_W        (LIFE_W),
    .IDX_W         (IDX_W)
  ) u_select (
    .occupied (occupied),
    .match    (match),
    .lifetime (lifetime),
    .status   (sel_status),
    .slot     (sel_slot)
  );

  // A beacon writes the table unless it is too long or no slot qualifies.
  assign res_write = !is_tick && !rejected && (sel_status != ST_DROPPED);
  assign wr_en     = req_fire && res_write;

  always_comb begin
    if (is_tick) begin
      res.status       = ST_TICK;
      res.slot         = '0;
      res.expired_mask = mask_low;
    end else if (rejected) begin
      res.status       = ST_REJECTED;
      res.slot         = '0;
      res.expired_mask = '0;
    end else begin
      res.status       = sel_status;
      res.slot         = res_write ? SLOT_W'(sel_slot) : '0;
      res.expired_mask = '0;
    end
  end

  // Lifetime and strength: a tick ages every live entry and empties those
  // that run out; a written beacon restarts the chosen entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= '0;
      strength <= '0;
    end else if (req_fire) begin
      if (is_tick) begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          lifetime[i] <= aged[i];
          if (expired[i]) begin
            strength[i] <= 8'd0;
          end
        end
      end else if (res_write) begin
        lifetime[sel_slot] <= LIFE_W'(FULL_LIFETIME);
        strength[sel_slot] <= req.signal_strength;
      end
    end
  end

  // Entry payload. SSID bytes at and beyond the length are stored as zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      channel[sel_slot]    <= req.channel;
      bssid[sel_slot]      <= req.bssid;
      ssid_len[sel_slot]   <= req.ssid_length[5:0];
      period[sel_slot]     <= req.beacon_period;
      capability[sel_slot] <= req.capability;
      for (int w = 0; w < SSID_WORDS; w++) begin
        ssid[sel_slot][w] <= ssid_in[w] & ssid_keep(req.ssid_length[5:0], 2'(w));
      end
    end
  end

  // Result queue bookkeeping.
  always_comb begin
    count_next = count;
    case ({req_fire, rsp_fire})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    case ({req_fire, rsp_fire})
      2'b11: begin
        if (count == 2'd2) begin
          head <= tail;
          tail <= res;
        end else begin
          head <= res;
        end
      end
      2'b10: begin
        if (count == 2'd0) begin
          head <= res;
        end else begin
          tail <= res;
        end
      end
      2'b01: begin
        head <= tail;
      end
      default: begin
        head <= head;
      end
    endcase
  end

  // The queue holds at most two results.
  `BAPT_ASSERT_NOW(a_count_range, clk, rst, count != 2'd3, "result queue count out of range")

  // A written slot must come out with a full lifetime.
  `BAPT_ASSERT_NEXT(a_write_full_life, clk, rst, wr_en, lifetime[$past(sel_slot)] == LIFE_W'(FULL_LIFETIME), "written slot lacks full lifetime")

  // A written slot takes the beacon's strength.
  `BAPT_ASSERT_NEXT(a_write_strength, clk, rst, wr_en, strength[$past(sel_slot)] == $past(req.signal_strength), "written slot lost beacon strength")

  // With the queue empty, a tick's result is presented on the next cycle.
  `BAPT_ASSERT_NEXT(a_tick_result, clk, rst, req_fire && is_tick && (count == 2'd0), rsp_valid && (rsp.status == ST_TICK), "tick result not presented")

  // An entry that runs out on a tick ends up empty with zero lifetime.
  for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_chk
    `BAPT_ASSERT_NEXT(a_expire_clears, clk, rst, req_fire && is_tick && expired[i], (strength[i] == 8'd0) && (lifetime[i] == '0), "expired entry not cleared")
  end

endmodule

/* hw/rtl/bapt_select.sv */
`timescale 1ns / 1ps

// Picks the slot a beacon goes to: the first occupied entry with the same
// BSSID, else the last empty entry, else the first occupied entry with the
// smallest lifetime below full. The oldest search is a balanced tree in
// which the lower index wins a tie.
module bapt_select import bapt_pkg::*; #(
  parameter int ENTRY_COUNT   = ENTRY_COUNT_DEF,
  parameter int FULL_LIFETIME = FULL_LIFETIME_DEF,
  parameter int LIFE_W        = $clog2(FULL_LIFETIME_DEF + 1),
  parameter int IDX_W         = $clog2(ENTRY_COUNT_DEF)
) (
  input  logic [ENTRY_COUNT-1:0]             occupied,
  input  logic [ENTRY_COUNT-1:0]             match,
  input  logic [ENTRY_COUNT-1:0][LIFE_W-1:0] lifetime,
  output status_t                            status,
  output logic [IDX_W-1:0]                   slot
);

  localparam int LEVELS = $clog2(ENTRY_COUNT);
  localparam int NP     = 1 << LEVELS;

  logic [2*NP-1:1]   node_ok;
  logic [LIFE_W-1:0] node_life [1:2*NP-1];
  logic [IDX_W-1:0]  node_idx  [1:2*NP-1];

  logic             match_any;
  logic [IDX_W-1:0] match_idx;
  logic             empty_any;
  logic [IDX_W-1:0] empty_idx;

  for (genvar k = 0; k < NP; k++) begin : g_leaf
    if (k < ENTRY_COUNT) begin : g_real
      assign node_ok[NP+k]   = occupied[k] && (lifetime[k] < LIFE_W'(FULL_LIFETIME));
      assign node_life[NP+k] = lifetime[k];
      assign node_idx[NP+k]  = IDX_W'(k);
    end else begin : g_pad
      assign node_ok[NP+k]   = 1'b0;
      assign node_life[NP+k] = '0;
      assign node_idx[NP+k]  = '0;
    end
  end

  for (genvar k = 1; k < NP; k++) begin : g_node
    logic take_left;
    assign take_left = node_ok[2*k] &&
                       (!node_ok[2*k+1] || (node_life[2*k] <= node_life[2*k+1]));
    assign node_ok[k]   = node_ok[2*k] || node_ok[2*k+1];
    assign node_life[k] = take_left ? node_life[2*k] : node_life[2*k+1];
    assign node_idx[k]  = take_left ? node_idx[2*k]  : node_idx[2*k+1];
  end

  always_comb begin
    match_idx = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
    end
    empty_idx = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (!occupied[i]) begin
        empty_idx = IDX_W'(i);
      end
    end
    match_any = |match;
    empty_any = ~&occupied;

    if (match_any) begin
      status = ST_MATCHED;
      slot   = match_idx;
    end else if (empty_any) begin
      status = ST_FILLED;
      slot   = empty_idx;
    end else if (node_ok[1]) begin
      status = ST_REPLACED;
      slot   = node_idx[1];
    end else begin
      status = ST_DROPPED;
      slot   = '0;
    end
  end

endmodule

/* sim/beacon_ap_table_update_unit_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the access point table update unit.
//
// Each accepted item runs through a local model of the table: the lifetimes, strengths and
// BSSIDs of the entries. The model works out the status, slot and expired mask that the
// item must produce, and that result waits in a queue. Each result taken from the block is
// compared, field by field, with the oldest result in the queue.
//
// The run starts with a short directed table that walks the table from empty to full:
// fills, a match, a drop on a full table, replacement of the entry with the least
// lifetime, and rejected SSID lengths. Random traffic follows in four phases with
// different idle patterns on both sides. Most random beacons come from a small pool of
// BSSIDs so that matches are common, and ticks are mixed in to age the entries.
module beacon_ap_table_update_unit_test;
  import bapt_pkg::*;

  // One row of the directed table. When fixed is set, want is the result written by
  // hand; otherwise the row is checked against the local model.
  typedef struct {
    req_t item;
    logic fixed;
    rsp_t want;
  } stim_row_t;

  localparam int RANDOM_PER_PHASE = 200;
  localparam int AP_POOL_SIZE     = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Idle percentages for the current phase. The sender reads send_idle_pct and the
  // receiver reads stall_pct, so each phase sets the two sides on their own.
  int send_idle_pct = 0;
  int stall_pct = 0;

  int mismatch_count = 0;

  // Local copy of the table: only the fields that steer slot choice and expiry.
  logic [10:0] ap_life     [ENTRY_COUNT_DEF];
  logic [7:0]  ap_strength [ENTRY_COUNT_DEF];
  logic [47:0] ap_bssid    [ENTRY_COUNT_DEF];

  // Results that are due from the block, oldest first.
  rsp_t table_outcomes_due[$];

  // Small set of BSSIDs that random beacons reuse, so that they hit existing entries.
  logic [47:0] ap_pool [AP_POOL_SIZE];

  stim_row_t directed_rows[$];

  beacon_ap_table_update_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Apply one item to the local table and return the result that it must produce.
  function automatic rsp_t update_ap_table(req_t x);
    rsp_t r;
    logic hit;
    logic has_empty;
    logic has_aged;
    int hit_i;
    int empty_i;
    int aged_i;
    int slot;
    logic [10:0] least;
    r = '{status: ST_TICK, slot: '0, expired_mask: '0};
    hit = 1'b0;
    has_empty = 1'b0;
    has_aged = 1'b0;
    hit_i = 0;
    empty_i = 0;
    aged_i = 0;
    least = 11'(FULL_LIFETIME_DEF);

    // A tick ages every live entry. An entry that runs out loses its strength and is
    // flagged in the mask; only entries 0 to 3 have a bit there.
    if (x.mode == MODE_TICK) begin
      for (int i = 0; i < ENTRY_COUNT_DEF; i++) begin
        if (ap_life[i] != 0) begin
          ap_life[i] = ap_life[i] - 1'b1;
          if (ap_life[i] == 0) begin
            ap_strength[i] = '0;
            if (i < MASK_W) r.expired_mask[i] = 1'b1;
          end
        end
      end
      return r;
    end

    if (x.ssid_length > SSID_MAX) begin
      r.status = ST_REJECTED;
      return r;
    end

    // Scan in slot order. The first occupied entry with the same BSSID wins at once.
    // Empty entries keep overwriting empty_i, so the last one is kept. Among the
    // occupied entries, only a strictly smaller lifetime moves aged_i, so the first one
    // with the least lifetime is kept. An entry at full lifetime never qualifies.
    for (int i = 0; i < ENTRY_COUNT_DEF; i++) begin
      if (ap_strength[i] != 0) begin
        if (ap_bssid[i] == x.bssid) begin
          hit = 1'b1;
          hit_i = i;
          break;
        end
        if (ap_life[i] < least) begin
          least = ap_life[i];
          aged_i = i;
          has_aged = 1'b1;
        end
      end else begin
        empty_i = i;
        has_empty = 1'b1;
      end
    end

    if (hit) begin
      slot = hit_i;
      r.status = ST_MATCHED;
    end else if (has_empty) begin
      slot = empty_i;
      r.status = ST_FILLED;
    end else if (has_aged) begin
      slot = aged_i;
      r.status = ST_REPLACED;
    end else begin
      r.status = ST_DROPPED;
      return r;
    end

    // A beacon with zero strength is stored as given, so its entry still counts as
    // empty, but it holds a lifetime and can expire later.
    ap_life[slot] = 11'(FULL_LIFETIME_DEF);
    ap_strength[slot] = x.signal_strength;
    ap_bssid[slot] = x.bssid;
    r.slot = SLOT_W'(slot);
    return r;
  endfunction

  function automatic req_t beacon_item(logic [47:0] id, logic [7:0] strength,
                                       logic [7:0] len, logic all_ones);
    req_t b;
    b = '0;
    if (all_ones) b = '1;
    b.mode = MODE_BEACON;
    b.bssid = id;
    b.signal_strength = strength;
    b.ssid_length = len;
    return b;
  endfunction

  function automatic req_t tick_item(logic all_ones);
    req_t t;
    t = '0;
    if (all_ones) t = '1;
    t.mode = MODE_TICK;
    return t;
  endfunction

  function automatic void add_row(req_t x, logic fixed, status_t st, logic [1:0] sl);
    stim_row_t row;
    row.item = x;
    row.fixed = fixed;
    row.want = '{status: st, slot: sl, expired_mask: '0};
    directed_rows.push_back(row);
  endfunction

  // A random item. Most beacons use the BSSID pool and a legal SSID length. A few use
  // lengths past the limit or zero strength.
  function automatic req_t random_item();
    req_t x;
    int roll;
    roll = $urandom_range(99);
    x.mode = MODE_BEACON;
    x.channel = 4'($urandom);
    x.bssid = 48'({$urandom, $urandom});
    x.signal_strength = 8'($urandom_range(255, 1));
    x.ssid_length = 8'($urandom_range(SSID_MAX, 0));
    x.ssid_word0 = {$urandom, $urandom};
    x.ssid_word1 = {$urandom, $urandom};
    x.ssid_word2 = {$urandom, $urandom};
    x.ssid_word3 = {$urandom, $urandom};
    x.beacon_period = 16'($urandom);
    x.capability = 16'($urandom);
    if (roll < 30) begin
      x.mode = MODE_TICK;
    end else begin
      if (roll < 85) x.bssid = ap_pool[$urandom_range(AP_POOL_SIZE - 1)];
      if ($urandom_range(9) == 0) x.signal_strength = '0;
      if ($urandom_range(9) == 0) x.ssid_length = 8'($urandom_range(255, SSID_MAX + 1));
    end
    return x;
  endfunction

  // Offer one item and hold it until the block accepts it. The caller sits right after
  // a rising edge. Idle cycles come first, so valid never drops while an item waits.
  task automatic send_item(req_t x, logic fixed, rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= x;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = update_ap_table(x);
    table_outcomes_due.push_back(fixed ? want : predicted);
  endtask

  // Stop offering items until every result that is due has arrived.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (table_outcomes_due.size() != 0) @(posedge clk);
  endtask

  function automatic void check_result(rsp_t got);
    rsp_t want;
    if (table_outcomes_due.size() == 0) begin
      mismatch_count++;
      $display("%0t: result with none expected: status=%0d slot=%0d expired=%b",
               $time, got.status, got.slot, got.expired_mask);
      return;
    end
    want = table_outcomes_due.pop_front();
    if (got.status !== want.status || got.slot !== want.slot ||
        got.expired_mask !== want.expired_mask) begin
      mismatch_count++;
      $display("%0t: expected status=%0d slot=%0d expired=%b, got status=%0d slot=%0d expired=%b",
               $time, want.status, want.slot, want.expired_mask,
               got.status, got.slot, got.expired_mask);
    end
  endfunction

  // Receiver: the handshake values are read just after the edge, before any register
  // has moved. The stall decision for the next cycle is made here too.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_result(rsp);
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < ENTRY_COUNT_DEF; i++) begin
      ap_life[i] = '0;
      ap_strength[i] = '0;
      ap_bssid[i] = '0;
    end
    for (int k = 0; k < AP_POOL_SIZE; k++) ap_pool[k] = 48'({$urandom, $urandom});

    // The directed walk, starting from an empty table. Slots fill from the top down,
    // because the last empty slot is taken.
    add_row(tick_item(1'b0), 1'b1, ST_TICK, 2'd0);
    add_row(beacon_item(48'h0000_0000_0000, 8'h10, 8'd33, 1'b0), 1'b1, ST_REJECTED, 2'd0);
    add_row(beacon_item(48'hFFFF_FFFF_FFFF, 8'hFF, 8'd255, 1'b1), 1'b1, ST_REJECTED, 2'd0);
    add_row(beacon_item(48'hFFFF_FFFF_FFFF, 8'hFF, 8'd32, 1'b1), 1'b1, ST_FILLED, 2'd3);
    add_row(beacon_item(48'hFFFF_FFFF_FFFF, 8'h01, 8'd0, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    // A zero strength beacon is stored, but its slot stays free for the next one.
    add_row(beacon_item(48'h0000_0000_0000, 8'h00, 8'd1, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'h0000_0000_0001, 8'h80, 8'd8, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'h8000_0000_0000, 8'h05, 8'd9, 1'b1), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'h5555_AAAA_5555, 8'h7F, 8'd31, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    // Every entry is occupied and at full lifetime, so a new BSSID finds no slot.
    add_row(beacon_item(48'h0123_4567_89AB, 8'h40, 8'd4, 1'b0), 1'b1, ST_DROPPED, 2'd0);
    add_row(tick_item(1'b1), 1'b0, ST_TICK, 2'd0);
    add_row(beacon_item(48'h0123_4567_89AB, 8'h40, 8'd4, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'hFFFF_FFFF_FFFF, 8'hFF, 8'd7, 1'b1), 1'b0, ST_MATCHED, 2'd0);
    add_row(tick_item(1'b0), 1'b0, ST_TICK, 2'd0);
    add_row(beacon_item(48'hFEDC_BA98_7654, 8'h22, 8'd16, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'h0000_0000_0000, 8'hFF, 8'd32, 1'b1), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'h0000_FFFF_0000, 8'h33, 8'd33, 1'b1), 1'b1, ST_REJECTED, 2'd0);
    // A matching beacon with zero strength empties its own entry, and the next new
    // BSSID moves into it.
    add_row(beacon_item(48'hFFFF_FFFF_FFFF, 8'h00, 8'd2, 1'b0), 1'b0, ST_MATCHED, 2'd0);
    add_row(beacon_item(48'h0000_FFFF_0000, 8'h33, 8'd5, 1'b0), 1'b0, ST_MATCHED, 2'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].want);
    drain_results();

    // Random phases: no idling, a slow sender, a slow receiver, then light idling on
    // both sides. Each phase ends with the sender held off until the queue of due
    // results is empty.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 73;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 73;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct = 10;
        end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        send_item(random_item(), 1'b0, '0);
      end
      drain_results();
    end

    // Leave time for a stray result to show up after the last one that was due.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
